### sv/salted_stretched_fnv_hash_assert.svh
// ----------------------------------------------------------------------------
// salted_stretched_fnv_hash_assert.svh
// Assertion macros for the salted stretched FNV hash block.
// ----------------------------------------------------------------------------
`ifndef SALTED_STRETCHED_FNV_HASH_ASSERT_SVH
`define SALTED_STRETCHED_FNV_HASH_ASSERT_SVH

`ifndef SYNTHESIS
// implication checked at each rising edge outside reset
`define SSHF_ASSERT(lbl, clk_s, rst_n_s, prop) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) \
		else $error("assertion failed");
// same, with a custom message
`define SSHF_ASSERT_MSG(lbl, clk_s, rst_n_s, prop, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) \
		else $error(msg);
`else
`define SSHF_ASSERT(lbl, clk_s, rst_n_s, prop)
`define SSHF_ASSERT_MSG(lbl, clk_s, rst_n_s, prop, msg)
`endif

`endif

### sv/sshf_pkg.sv
// ----------------------------------------------------------------------------
// sshf_pkg
// Types and constants shared by the salted stretched FNV hash block.
// ----------------------------------------------------------------------------
package sshf_pkg;

	localparam int unsigned HASH_W   = 64;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned ROUNDS_W = 16;

	localparam logic [HASH_W-1:0]   FNV_BASIS     = 64'hcbf29ce484222325;
	// prime = 2^40 + 0x1b3
	localparam int unsigned         PRIME_SHIFT   = 40;
	localparam int unsigned         PRIME_LO_W    = 9;
	localparam logic [PRIME_LO_W-1:0] PRIME_LO    = 9'h1b3;
	localparam int unsigned         MIX_SHIFT     = 27;
	localparam logic [ROUNDS_W-1:0] STRETCH_RESET = 16'd4096;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FOLD,
		ST_CHECK,
		ST_RMUL,
		ST_RMIX
	} state_t;

	typedef struct packed {
		logic accept;
		logic fold;
		logic rmul;
		logic rmix;
		logic emit;
	} ctrl_t;

endpackage

### sv/sshf_ifs.sv
// ----------------------------------------------------------------------------
// sshf_ifs
// Valid/ready channels: password bytes in, hash out, round count config.
// ----------------------------------------------------------------------------
interface sshf_in_if;
	logic                          valid;
	logic                          ready;
	logic [sshf_pkg::HASH_W-1:0]   salt;
	logic [sshf_pkg::BYTE_W-1:0]   data_byte;
	logic                          byte_valid;
	logic                          last;

	modport source (output valid, salt, data_byte, byte_valid, last, input ready);
	modport sink (input valid, salt, data_byte, byte_valid, last, output ready);
endinterface

interface sshf_out_if;
	logic                        valid;
	logic                        ready;
	logic [sshf_pkg::HASH_W-1:0] hash;

	modport source (output valid, hash, input ready);
	modport sink (input valid, hash, output ready);
endinterface

interface sshf_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [sshf_pkg::ROUNDS_W-1:0] stretch_rounds;

	modport source (output valid, stretch_rounds, input ready);
	modport sink (input valid, stretch_rounds, output ready);
endinterface

### sv/sshf_prime_mul.sv
// ----------------------------------------------------------------------------
// sshf_prime_mul
// Shared multiply by the 64-bit FNV prime, modulo 2^64.
// ----------------------------------------------------------------------------
module sshf_prime_mul (
	input  logic [sshf_pkg::HASH_W-1:0] a,
	output logic [sshf_pkg::HASH_W-1:0] p
);

	localparam int unsigned LP_W = sshf_pkg::HASH_W + sshf_pkg::PRIME_LO_W;

	logic [LP_W-1:0] lo_prod;

	// a * 0x1b3 plus a << 40
	assign lo_prod = {{sshf_pkg::PRIME_LO_W{1'b0}}, a}
		* {{sshf_pkg::HASH_W{1'b0}}, sshf_pkg::PRIME_LO};
	assign p = lo_prod[sshf_pkg::HASH_W-1:0]
		+ {a[sshf_pkg::HASH_W-sshf_pkg::PRIME_SHIFT-1:0],
			{sshf_pkg::PRIME_SHIFT{1'b0}}};

endmodule

### sv/sshf_seq.sv
// ----------------------------------------------------------------------------
// sshf_seq
// Sequencer: byte intake, fold step and stretching round loop.
// ----------------------------------------------------------------------------
`include "salted_stretched_fnv_hash_assert.svh"

module sshf_seq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  logic                          byte_valid,
	input  logic                          last,
	input  logic                          out_free,
	input  logic [sshf_pkg::ROUNDS_W-1:0] rounds,
	output logic                          in_ready,
	output sshf_pkg::ctrl_t               ctrl
);

	sshf_pkg::state_t              state_q, state_d;
	logic                          last_q;
	logic [sshf_pkg::ROUNDS_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= sshf_pkg::ST_IDLE;
			last_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ctrl.accept) begin
				last_q <= last;
			end
			if (ctrl.emit) begin
				cnt_q <= '0;
			end else if (ctrl.rmul) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		ctrl     = '0;
		unique case (state_q)
			sshf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.accept = 1'b1;
					if (byte_valid) begin
						state_d = sshf_pkg::ST_FOLD;
					end else if (last) begin
						state_d = sshf_pkg::ST_CHECK;
					end
				end
			end
			sshf_pkg::ST_FOLD: begin
				ctrl.fold = 1'b1;
				state_d   = last_q ? sshf_pkg::ST_CHECK : sshf_pkg::ST_IDLE;
			end
			sshf_pkg::ST_CHECK: begin
				if (cnt_q == rounds) begin
					if (out_free) begin
						ctrl.emit = 1'b1;
						state_d   = sshf_pkg::ST_IDLE;
					end
				end else begin
					state_d = sshf_pkg::ST_RMUL;
				end
			end
			sshf_pkg::ST_RMUL: begin
				ctrl.rmul = 1'b1;
				state_d   = sshf_pkg::ST_RMIX;
			end
			sshf_pkg::ST_RMIX: begin
				ctrl.rmix = 1'b1;
				state_d   = sshf_pkg::ST_CHECK;
			end
			default: begin
				state_d = sshf_pkg::ST_IDLE;
			end
		endcase
	end

	`SSHF_ASSERT(a_rmul_then_rmix, clk, arst_n, ctrl.rmul |=> ctrl.rmix)
	`SSHF_ASSERT(a_emit_slot_free, clk, arst_n, ctrl.emit |-> out_free)
	`SSHF_ASSERT_MSG(a_emit_resets, clk, arst_n,
		ctrl.emit |=> (state_q == sshf_pkg::ST_IDLE && cnt_q == '0),
		"round counter not cleared after result")
	`SSHF_ASSERT(a_fold_after_byte, clk, arst_n,
		ctrl.fold |-> ($past(ctrl.accept) && $past(byte_valid)))

endmodule

### sv/salted_stretched_fnv_hash.sv
// ----------------------------------------------------------------------------
// salted_stretched_fnv_hash
// Salted FNV-1a 64-bit password hash with key stretching rounds.
// ----------------------------------------------------------------------------
// Channels: din takes one password byte per word (salt, data_byte,
// byte_valid, last); the salt is read on the first word of a password.
// dout gives one 64-bit hash per password, after the word with last set.
// cfg writes stretch_rounds (R); write it only while the block is idle.
// Sequence: a word with a byte is taken in, then makes one pass through
// the shared prime multiplier; a word without a byte is only taken in.
// After the last word the sequencer runs R rounds of check, multiply and
// xor-shift on the single multiplier, then registers the hash once the
// output register is free. din.ready is low meanwhile.
// The hash sits in an output register: a new password can start while it
// waits. If dout stalls and a second hash is done, the sequencer holds it
// until the register frees up.
// Reset: R returns to 4096, no password in progress, dout empty.
// ----------------------------------------------------------------------------
module salted_stretched_fnv_hash (
	input  logic clk,
	input  logic arst_n,
	sshf_in_if.sink    din,
	sshf_out_if.source dout,
	sshf_cfg_if.sink   cfg
);

	localparam int unsigned HW = sshf_pkg::HASH_W;

	logic [sshf_pkg::ROUNDS_W-1:0] rounds_q;
	logic                          in_pw_q;
	logic [HW-1:0]                 h_q;
	logic [HW-1:0]                 opnd_q;
	logic [HW-1:0]                 sp_q;
	logic [HW-1:0]                 hash_q;
	logic                          out_valid_q;

	logic [HW-1:0]   base;
	logic [HW-1:0]   mul_a;
	logic [HW-1:0]   mul_p;
	logic            out_free;
	sshf_pkg::ctrl_t ctrl;

	assign cfg.ready  = 1'b1;
	assign dout.valid = out_valid_q;
	assign dout.hash  = hash_q;
	assign out_free   = !out_valid_q || dout.ready;

	assign base  = in_pw_q ? h_q : (din.salt ^ sshf_pkg::FNV_BASIS);
	assign mul_a = ctrl.fold ? opnd_q : (h_q ^ sp_q);

	sshf_prime_mul u_mul (
		.a(mul_a),
		.p(mul_p)
	);

	sshf_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (din.valid),
		.byte_valid(din.byte_valid),
		.last      (din.last),
		.out_free  (out_free),
		.rounds    (rounds_q),
		.in_ready  (din.ready),
		.ctrl      (ctrl)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rounds_q    <= sshf_pkg::STRETCH_RESET;
			in_pw_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid) begin
				rounds_q <= cfg.stretch_rounds;
			end
			if (ctrl.emit) begin
				in_pw_q <= 1'b0;
			end else if (ctrl.accept) begin
				in_pw_q <= 1'b1;
			end
			if (ctrl.emit) begin
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (ctrl.accept) begin
			if (!in_pw_q) begin
				sp_q <= din.salt;
			end
			if (din.byte_valid) begin
				opnd_q <= base ^ {{(HW-sshf_pkg::BYTE_W){1'b0}}, din.data_byte};
			end else begin
				h_q <= base;
			end
		end
		if (ctrl.fold) begin
			h_q <= mul_p;
		end
		if (ctrl.rmul) begin
			h_q  <= mul_p;
			sp_q <= sp_q + 1'b1;
		end
		if (ctrl.rmix) begin
			h_q <= h_q ^ (h_q >> sshf_pkg::MIX_SHIFT);
		end
		if (ctrl.emit) begin
			hash_q <= h_q;
		end
	end

endmodule

### dv/tb_salted_stretched_fnv_hash.sv
// ----------------------------------------------------------------------------
// tb_salted_stretched_fnv_hash
// Self-checking bench for the salted stretched FNV-1a password hash. Words
// are queued per phase and driven with random gaps, and hashes are taken with
// random stalls. An in-bench predictor works out each hash when the word with
// last set is accepted, and every hash out is compared in order. The round
// count runs through its reset value, zero, the maximum and several small
// settings, written only while the block is idle.
// ----------------------------------------------------------------------------
module tb_salted_stretched_fnv_hash;

	localparam int unsigned         HASH_W        = sshf_pkg::HASH_W;
	localparam int unsigned         BYTE_W        = sshf_pkg::BYTE_W;
	localparam int unsigned         ROUNDS_W      = sshf_pkg::ROUNDS_W;
	localparam int unsigned         MIX_SHIFT     = sshf_pkg::MIX_SHIFT;
	localparam logic [HASH_W-1:0]   FNV_BASIS     = sshf_pkg::FNV_BASIS;
	localparam logic [ROUNDS_W-1:0] STRETCH_RESET = sshf_pkg::STRETCH_RESET;

	localparam logic [HASH_W-1:0] FNV_PRIME   = 64'h100000001b3;
	localparam int unsigned       CYCLE_LIMIT = 3000000;
	localparam int unsigned       PHASE_WORDS = 225;

	typedef struct {
		logic [HASH_W-1:0] salt;
		logic [BYTE_W-1:0] data_byte;
		logic              byte_valid;
		logic              last;
		bit                drain_first;
	} word_t;

	logic clk;
	logic arst_n;

	sshf_in_if  din_if ();
	sshf_out_if dout_if ();
	sshf_cfg_if cfg_if ();

	salted_stretched_fnv_hash u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din_if),
		.dout   (dout_if),
		.cfg    (cfg_if)
	);

	word_t             pend_q[$];
	logic [HASH_W-1:0] hash_q[$];

	logic [ROUNDS_W-1:0] rounds_cfg = STRETCH_RESET;
	logic [HASH_W-1:0]   pw_salt = '0;
	logic [HASH_W-1:0]   pw_hash = '0;
	bit                  pw_open = 1'b0;

	int unsigned words_queued = 0;
	int unsigned words_taken  = 0;
	int unsigned errors       = 0;
	int unsigned cycles       = 0;
	int unsigned gap_max      = 0;
	int unsigned stall_max    = 0;
	int unsigned in_gap       = 0;
	int unsigned out_stall    = 0;
	bit          in_taken     = 1'b0;
	bit          out_taken    = 1'b0;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [HASH_W-1:0] got,
			input logic [HASH_W-1:0] want);
		errors++;
		$display("mismatch at cycle %0d: %s got %h want %h", cycles, what, got, want);
	endtask

	function automatic void predict_hash(input word_t w);
		logic [HASH_W-1:0] h;
		if (!pw_open) begin
			pw_salt = w.salt;
			pw_hash = w.salt ^ FNV_BASIS;
			pw_open = 1'b1;
		end
		if (w.byte_valid)
			pw_hash = (pw_hash ^ {{(HASH_W-BYTE_W){1'b0}}, w.data_byte}) * FNV_PRIME;
		if (w.last) begin
			h = pw_hash;
			for (int unsigned r = 0; r < rounds_cfg; r++) begin
				h = h ^ (pw_salt + HASH_W'(r));
				h = h * FNV_PRIME;
				h = h ^ (h >> MIX_SHIFT);
			end
			hash_q = {hash_q, h};
			pw_open = 1'b0;
		end
	endfunction

	// monitor: both handshakes sampled at the rising edge
	always @(posedge clk) begin : monitor
		word_t w;
		in_taken  = 1'b0;
		out_taken = 1'b0;
		if (arst_n) begin
			if (din_if.valid && din_if.ready) begin
				in_taken = 1'b1;
				words_taken++;
				w.salt        = din_if.salt;
				w.data_byte   = din_if.data_byte;
				w.byte_valid  = din_if.byte_valid;
				w.last        = din_if.last;
				w.drain_first = 1'b0;
				predict_hash(w);
			end
			if (dout_if.valid && dout_if.ready) begin
				out_taken = 1'b1;
				if (hash_q.size() == 0)
					report_mismatch("unexpected hash", dout_if.hash, '0);
				else if (dout_if.hash !== hash_q[0])
					report_mismatch("hash", dout_if.hash, hash_q.pop_front());
				else
					void'(hash_q.pop_front());
			end
		end
	end

	// word driver
	always @(negedge clk) begin : driver
		word_t w;
		bit    blocked;
		if (arst_n && !(din_if.valid && !in_taken)) begin
			blocked = pend_q.size() == 0 || (pend_q[0].drain_first && hash_q.size() != 0);
			if (in_gap > 0) begin
				in_gap--;
				din_if.valid <= 1'b0;
			end else if (!blocked) begin
				w = pend_q.pop_front();
				din_if.salt       <= w.salt;
				din_if.data_byte  <= w.data_byte;
				din_if.byte_valid <= w.byte_valid;
				din_if.last       <= w.last;
				din_if.valid      <= 1'b1;
				in_gap = $urandom_range(0, gap_max);
			end else begin
				din_if.valid <= 1'b0;
			end
		end
	end

	// hash sink
	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken)
				out_stall = $urandom_range(0, stall_max);
			if (out_stall > 0) begin
				out_stall--;
				dout_if.ready <= 1'b0;
			end else begin
				dout_if.ready <= 1'b1;
			end
		end
	end

	task automatic push_word(input logic [HASH_W-1:0] salt, input logic [BYTE_W-1:0] b,
			input logic v, input logic l, input bit drain);
		word_t w;
		w.salt        = salt;
		w.data_byte   = b;
		w.byte_valid  = v;
		w.last        = l;
		w.drain_first = drain;
		pend_q = {pend_q, w};
		words_queued++;
	endtask

	function automatic logic [HASH_W-1:0] rand_salt();
		int unsigned pick;
		pick = $urandom_range(0, 7);
		if (pick == 0)
			return '0;
		if (pick == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	task automatic push_password();
		int unsigned len;
		int unsigned pick;
		bit          drain;
		pick  = $urandom_range(0, 15);
		drain = $urandom_range(0, 19) == 0;
		if (pick < 12)
			len = $urandom_range(1, 8);
		else if (pick < 14)
			len = 0;
		else
			len = $urandom_range(9, 40);
		if (len == 0) begin
			push_word(rand_salt(), 8'($urandom), 1'b0, 1'b1, drain);
		end else begin
			for (int unsigned i = 0; i < len; i++)
				push_word(i == 0 ? rand_salt() : {$urandom, $urandom}, 8'($urandom),
					$urandom_range(0, 9) != 0, i == len - 1, drain && i == 0);
		end
	endtask

	task automatic wait_idle();
		do @(negedge clk);
		while (words_taken != words_queued || hash_q.size() != 0);
		repeat (16) @(negedge clk);
	endtask

	task automatic write_rounds(input logic [ROUNDS_W-1:0] value);
		@(negedge clk);
		cfg_if.stretch_rounds <= value;
		cfg_if.valid          <= 1'b1;
		do @(posedge clk);
		while (!cfg_if.ready);
		rounds_cfg = value;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	initial begin : stimulus
		int unsigned phase_start;
		int unsigned setting[8];
		setting = '{2, 0, 7, 1, 100, 3, 5, 0};

		arst_n                = 1'b0;
		din_if.valid          = 1'b0;
		din_if.salt           = '0;
		din_if.data_byte      = '0;
		din_if.byte_valid     = 1'b0;
		din_if.last           = 1'b0;
		dout_if.ready         = 1'b0;
		cfg_if.valid          = 1'b0;
		cfg_if.stretch_rounds = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset round count: empty password, plain bytes, word without a byte first
		push_word('0, 8'h00, 1'b0, 1'b1, 1'b0);
		push_word('1, 8'h61, 1'b1, 1'b0, 1'b0);
		push_word('0, 8'h62, 1'b1, 1'b0, 1'b0);
		push_word('0, 8'h63, 1'b1, 1'b1, 1'b0);
		push_word(64'h0123456789abcdef, 8'h00, 1'b0, 1'b0, 1'b0);
		push_word('1, 8'h00, 1'b1, 1'b0, 1'b0);
		push_word(64'hfedcba9876543210, 8'hff, 1'b1, 1'b0, 1'b0);
		push_word('0, 8'ha5, 1'b0, 1'b1, 1'b0);
		wait_idle();

		// no stretching, with gaps and stalls
		gap_max   = 16;
		stall_max = 16;
		write_rounds('0);
		push_word('1, 8'h00, 1'b0, 1'b1, 1'b0);
		push_word('0, 8'hff, 1'b1, 1'b1, 1'b0);
		push_word('1, 8'h00, 1'b1, 1'b1, 1'b1);
		push_word(64'h8000000000000001, 8'h80, 1'b0, 1'b0, 1'b0);
		push_word('0, 8'h7f, 1'b1, 1'b1, 1'b0);
		wait_idle();

		// maximum round count, one password only
		write_rounds('1);
		push_word({$urandom, $urandom}, 8'h5a, 1'b1, 1'b1, 1'b0);
		wait_idle();

		write_rounds(16'd1);
		push_word('1, 8'hff, 1'b1, 1'b0, 1'b0);
		push_word('1, 8'h01, 1'b1, 1'b1, 1'b0);
		push_word(64'h5555aaaa5555aaaa, 8'h00, 1'b0, 1'b1, 1'b0);
		wait_idle();

		for (int p = 0; p < 8; p++) begin
			gap_max   = (p % 3 == 0) ? 0 : 16;
			stall_max = (p % 3 == 2) ? 0 : 16;
			write_rounds(ROUNDS_W'(setting[p]));
			phase_start = words_queued;
			while (words_queued - phase_start < PHASE_WORDS)
				push_password();
			wait_idle();
		end

		repeat (32) @(negedge clk);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

### salted_stretched_fnv_hash.f
+incdir+sv
sv/sshf_pkg.sv
sv/sshf_ifs.sv
sv/sshf_prime_mul.sv
sv/sshf_seq.sv
sv/salted_stretched_fnv_hash.sv
dv/tb_salted_stretched_fnv_hash.sv
